// ===== rtl/copy_page_boundary_splitter_unit_defines.svh =====
// Assertion macros shared by the splitter RTL.
`ifndef COPY_PAGE_BOUNDARY_SPLITTER_UNIT_DEFINES_SVH
`define COPY_PAGE_BOUNDARY_SPLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cpbs_pkg.sv =====
// Shared types and constants of the copy page boundary splitter.
`timescale 1ns / 1ps

package cpbs_pkg;

   // Fixed field widths
   localparam int SEG_LEN_W   = 32;
   localparam int OFF_W       = 12;
   localparam int IDX_W       = 5;
   localparam int CHUNK_LEN_W = 13;
   localparam int STATUS_W    = 2;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USED_W  = 2 * OFF_W + 2 * IDX_W + CHUNK_LEN_W;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_CHUNK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DST_BIG = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SRC_BIG = 2'd2;

   // Step unit operations
   typedef enum logic [1:0] {
      OP_CHECK_DST,
      OP_CHECK_SRC,
      OP_CHUNK
   } step_op_type;

   // Step unit flags
   typedef struct packed {
      logic over;       // offset + length spans too many pages
      logic cross_src;  // chunk ends at a source page boundary
      logic cross_dst;  // chunk ends at a destination page boundary
      logic done;       // chunk consumes the rest of the segment
   } step_flags_type;

endpackage

// ===== rtl/cpbs_step_unit.sv =====
// Shared step unit: page span check and chunk length calculation.
`timescale 1ns / 1ps

module cpbs_step_unit #(
   parameter int PAGE_BITS = 12,
   parameter int MAX_PAGES = 32
) (
   input  cpbs_pkg::step_op_type            op,
   input  logic [PAGE_BITS-1:0]             src_off,
   input  logic [PAGE_BITS-1:0]             dst_off,
   input  logic [cpbs_pkg::SEG_LEN_W-1:0]   remaining,
   output logic [PAGE_BITS:0]               len,
   output logic [cpbs_pkg::SEG_LEN_W-1:0]   remaining_next,
   output cpbs_pkg::step_flags_type         flags
);

   localparam int                      LEN_W   = cpbs_pkg::SEG_LEN_W;
   localparam int unsigned             LIMIT_I = MAX_PAGES * (2 ** PAGE_BITS);
   localparam logic [LEN_W:0]          LIMIT   = (LEN_W + 1)'(LIMIT_I);
   localparam logic [PAGE_BITS:0]      PSZ     = (PAGE_BITS + 1)'(2 ** PAGE_BITS);

   logic [PAGE_BITS-1:0] chk_off;
   logic [LEN_W:0]       span_sum;
   logic [PAGE_BITS:0]   room_src;
   logic [PAGE_BITS:0]   room_dst;
   logic [PAGE_BITS:0]   room_min;
   logic                 rem_short;

   // span check: ceil((off + len) / page) > MAX_PAGES  <=>  off + len > MAX_PAGES * page
   assign chk_off  = (op == cpbs_pkg::OP_CHECK_SRC) ? src_off : dst_off;
   assign span_sum = {1'b0, remaining} + (LEN_W + 1)'(chk_off);

   assign room_src  = PSZ - {1'b0, src_off};
   assign room_dst  = PSZ - {1'b0, dst_off};
   assign room_min  = (room_src < room_dst) ? room_src : room_dst;
   assign rem_short = remaining < LEN_W'(room_min);

   assign len            = rem_short ? remaining[PAGE_BITS:0] : room_min;
   assign remaining_next = remaining - LEN_W'(len);

   always_comb begin
      flags.over      = (op != cpbs_pkg::OP_CHUNK) && (span_sum > LIMIT);
      flags.cross_src = (len == room_src);
      flags.cross_dst = (len == room_dst);
      flags.done      = (remaining_next == '0);
   end

endmodule

// ===== rtl/copy_page_boundary_splitter_unit.sv =====
// Top level of the copy page boundary splitter.
// Each request item is one copy segment (src_base, dst_base, length,
// tlast = last segment of the request). The block first checks that the destination and
// then the source span at most MAX_PAGES pages, one check per cycle on the shared step
// unit; a failing check gives a single error item (tuser = status, tlast = 1) and drops
// the later segments of the request up to and including the one with tlast set. A passing
// segment is cut into chunks that cross no source or destination page boundary, one chunk
// item per cycle while the response side takes them, the last chunk carrying tlast. A
// segment passes through the accept, the destination check, the source check and one
// chunk step per item; a failing check leads to an error step instead, and zero-length
// and dropped segments end at the accept. A busy response side holds the chunk and error
// steps. The sequencer takes a new segment only once the previous one has handed its
// final item to the response register. No clearing pass follows reset.
`timescale 1ns / 1ps
`include "copy_page_boundary_splitter_unit_defines.svh"

module copy_page_boundary_splitter_unit #(
   parameter int PAGE_BITS  = 12,
   parameter int MAX_PAGES  = 32,
   parameter int ADDR_WIDTH = 48,
   localparam int REQ_DATA_W = ((2 * ADDR_WIDTH + cpbs_pkg::SEG_LEN_W + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = src_base, dst_base, seg_length (from bit 0 up), zero padded
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_W-1:0]               req_tdata,
   input  logic                                req_tlast,   // last_in_request
   // response: tdata = src_offset, dst_offset, src_page_index, dst_page_index,
   //           chunk_length (from bit 0 up), zero padded
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cpbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [cpbs_pkg::STATUS_W-1:0]       rsp_tuser,   // status
   output logic                                rsp_tlast    // last
);

   localparam int LEN_W = cpbs_pkg::SEG_LEN_W;
   localparam logic [PAGE_BITS:0] PSZ = (PAGE_BITS + 1)'(2 ** PAGE_BITS);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CHECK_DST = 3'd1;
   localparam logic [2:0] ST_CHECK_SRC = 3'd2;
   localparam logic [2:0] ST_ERROR     = 3'd3;
   localparam logic [2:0] ST_CHUNK     = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic                           failed_ff, failed_in;
   logic                           last_req_ff, last_req_in;
   logic [cpbs_pkg::STATUS_W-1:0]  err_status_ff, err_status_in;
   logic [PAGE_BITS-1:0]           soff_ff, soff_in;
   logic [PAGE_BITS-1:0]           doff_ff, doff_in;
   logic [LEN_W-1:0]               rem_ff, rem_in;
   logic [cpbs_pkg::IDX_W-1:0]     si_ff, si_in;
   logic [cpbs_pkg::IDX_W-1:0]     di_ff, di_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cpbs_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [cpbs_pkg::OFF_W-1:0]        rsp_soff_ff, rsp_soff_in;
   logic [cpbs_pkg::OFF_W-1:0]        rsp_doff_ff, rsp_doff_in;
   logic [cpbs_pkg::IDX_W-1:0]        rsp_si_ff, rsp_si_in;
   logic [cpbs_pkg::IDX_W-1:0]        rsp_di_ff, rsp_di_in;
   logic [cpbs_pkg::CHUNK_LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic                              rsp_last_ff, rsp_last_in;

   // step unit
   cpbs_pkg::step_op_type     step_op;
   logic [PAGE_BITS:0]        step_len;
   logic [LEN_W-1:0]          step_rem_next;
   cpbs_pkg::step_flags_type  step_flags;

   logic req_accept;
   logic out_free;
   logic [LEN_W-1:0] req_len;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_len    = req_tdata[2*ADDR_WIDTH +: LEN_W];

   always_comb begin
      unique case (state_ff)
         ST_CHECK_SRC: step_op = cpbs_pkg::OP_CHECK_SRC;
         ST_CHUNK:     step_op = cpbs_pkg::OP_CHUNK;
         default:      step_op = cpbs_pkg::OP_CHECK_DST;
      endcase
   end

   cpbs_step_unit #(
      .PAGE_BITS (PAGE_BITS),
      .MAX_PAGES (MAX_PAGES)
   ) u_step (
      .op             (step_op),
      .src_off        (soff_ff),
      .dst_off        (doff_ff),
      .remaining      (rem_ff),
      .len            (step_len),
      .remaining_next (step_rem_next),
      .flags          (step_flags)
   );

   always_comb begin
      state_in      = state_ff;
      failed_in     = failed_ff;
      last_req_in   = last_req_ff;
      err_status_in = err_status_ff;
      soff_in       = soff_ff;
      doff_in       = doff_ff;
      rem_in        = rem_ff;
      si_in         = si_ff;
      di_in         = di_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_soff_in   = rsp_soff_ff;
      rsp_doff_in   = rsp_doff_ff;
      rsp_si_in     = rsp_si_ff;
      rsp_di_in     = rsp_di_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               soff_in     = req_tdata[PAGE_BITS-1:0];
               doff_in     = req_tdata[ADDR_WIDTH +: PAGE_BITS];
               rem_in      = req_len;
               last_req_in = req_tlast;
               si_in       = '0;
               di_in       = '0;
               // dropped segment of a failed request: only tlast matters
               if (failed_ff) begin
                  if (req_tlast) begin
                     failed_in = 1'b0;
                  end
               end else if (req_len != '0) begin
                  state_in = ST_CHECK_DST;
               end
            end
         end
         ST_CHECK_DST: begin
            if (step_flags.over) begin
               err_status_in = cpbs_pkg::STATUS_DST_BIG;
               state_in      = ST_ERROR;
            end else begin
               state_in = ST_CHECK_SRC;
            end
         end
         ST_CHECK_SRC: begin
            if (step_flags.over) begin
               err_status_in = cpbs_pkg::STATUS_SRC_BIG;
               state_in      = ST_ERROR;
            end else begin
               state_in = ST_CHUNK;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_status_ff;
               rsp_soff_in   = '0;
               rsp_doff_in   = '0;
               rsp_si_in     = '0;
               rsp_di_in     = '0;
               rsp_len_in    = '0;
               rsp_last_in   = 1'b1;
               // an error on the request's final segment leaves the flag clear
               failed_in     = !last_req_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_CHUNK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cpbs_pkg::STATUS_CHUNK;
               rsp_soff_in   = cpbs_pkg::OFF_W'(soff_ff);
               rsp_doff_in   = cpbs_pkg::OFF_W'(doff_ff);
               rsp_si_in     = si_ff;
               rsp_di_in     = di_ff;
               rsp_len_in    = cpbs_pkg::CHUNK_LEN_W'(step_len);
               rsp_last_in   = step_flags.done;
               soff_in       = PAGE_BITS'({1'b0, soff_ff} + step_len);
               doff_in       = PAGE_BITS'({1'b0, doff_ff} + step_len);
               rem_in        = step_rem_next;
               si_in         = si_ff + cpbs_pkg::IDX_W'(step_flags.cross_src);
               di_in         = di_ff + cpbs_pkg::IDX_W'(step_flags.cross_dst);
               if (step_flags.done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_req_ff   <= last_req_in;
      err_status_ff <= err_status_in;
      soff_ff       <= soff_in;
      doff_ff       <= doff_in;
      rem_ff        <= rem_in;
      si_ff         <= si_in;
      di_ff         <= di_in;
      rsp_status_ff <= rsp_status_in;
      rsp_soff_ff   <= rsp_soff_in;
      rsp_doff_ff   <= rsp_doff_in;
      rsp_si_ff     <= rsp_si_in;
      rsp_di_ff     <= rsp_di_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(cpbs_pkg::RSP_DATA_W - cpbs_pkg::RSP_USED_W)'(0),
                        rsp_len_ff, rsp_di_ff, rsp_si_ff, rsp_doff_ff, rsp_soff_ff};

   // error items are always the sole, final item of their segment
   `CPBS_ASSERT_NOW(a_err_is_last, clock, reset,
      rsp_valid_ff && (rsp_status_ff != cpbs_pkg::STATUS_CHUNK), rsp_last_ff && (rsp_len_ff == '0),
      "error item without tlast or with nonzero length")
   // chunk items carry a length between 1 and one page
   `CPBS_ASSERT_NOW(a_chunk_len, clock, reset,
      rsp_valid_ff && (rsp_status_ff == cpbs_pkg::STATUS_CHUNK),
      (rsp_len_ff != '0) && ((PAGE_BITS + 1)'(rsp_len_ff) <= PSZ),
      "chunk length out of range")
   // a segment of a failed request produces nothing
   `CPBS_ASSERT_NEXT(a_drop_failed, clock, reset,
      req_accept && failed_ff, state_ff == ST_IDLE,
      "dropped segment started the sequencer")
   // a chunk step never runs with nothing left
   `CPBS_ASSERT_NOW(a_chunk_rem, clock, reset,
      state_ff == ST_CHUNK, rem_ff != '0,
      "chunk step with empty remainder")

endmodule

// ===== tb/copy_page_boundary_splitter_unit_tb.sv =====
// Self-checking testbench for the copy page boundary splitter.
`timescale 1ns / 1ps

module copy_page_boundary_splitter_unit_tb;

   localparam int PAGE_BITS  = 12;
   localparam int MAX_PAGES  = 32;
   localparam int ADDR_WIDTH = 48;
   localparam int REQ_W      = ((2 * ADDR_WIDTH + cpbs_pkg::SEG_LEN_W + 7) / 8) * 8;

   // response tdata layout, lowest field first
   localparam int SO_LSB = 0;
   localparam int DO_LSB = cpbs_pkg::OFF_W;
   localparam int SI_LSB = 2 * cpbs_pkg::OFF_W;
   localparam int DI_LSB = 2 * cpbs_pkg::OFF_W + cpbs_pkg::IDX_W;
   localparam int CL_LSB = 2 * cpbs_pkg::OFF_W + 2 * cpbs_pkg::IDX_W;

   localparam int N_ITEMS       = 210;   // lower bound on segments sent in total
   localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
   localparam int STALL_LIMIT   = 4000;  // cycles without any transfer
   localparam int DRAIN_CYCLES  = 100;   // cycles waited after the final drain

   typedef struct packed {
      logic [cpbs_pkg::STATUS_W-1:0]    status;
      logic [cpbs_pkg::OFF_W-1:0]       src_off;
      logic [cpbs_pkg::OFF_W-1:0]       dst_off;
      logic [cpbs_pkg::IDX_W-1:0]       src_idx;
      logic [cpbs_pkg::IDX_W-1:0]       dst_idx;
      logic [cpbs_pkg::CHUNK_LEN_W-1:0] len;
      logic                             last;
   } chunk_type;

   // Turns each accepted segment into its expected chunk or error items, then matches
   // response items against them in order.
   class chunk_scoreboard;
      chunk_type expected_chunks[$];
      bit     request_failed;
      int     mismatches;
      int     segments;
      int     dropped;
      int     chunks_seen;
      int     errors_seen;

      function automatic longint unsigned page_span(longint unsigned off, longint unsigned len);
         return (off + len + (64'd1 << PAGE_BITS) - 1) >> PAGE_BITS;
      endfunction

      function automatic void push_error(logic [cpbs_pkg::STATUS_W-1:0] code, logic last_req);
         chunk_type c;
         c = '0;
         c.status = code;
         c.last   = 1'b1;
         expected_chunks.push_back(c);
         request_failed = !last_req;
      endfunction

      function automatic void plan_segment(logic [47:0] src, logic [47:0] dst,
                                           logic [31:0] seg_len, logic last_req);
         longint unsigned page_sz;
         longint unsigned soff;
         longint unsigned doff;
         longint unsigned left;
         longint unsigned step;
         logic [cpbs_pkg::IDX_W-1:0] si;
         logic [cpbs_pkg::IDX_W-1:0] di;
         chunk_type c;
         page_sz  = 64'd1 << PAGE_BITS;
         soff     = 64'(src) & (page_sz - 1);
         doff     = 64'(dst) & (page_sz - 1);
         left     = 64'(seg_len);
         si       = '0;
         di       = '0;
         segments++;
         // dropped segments inside a failed request; the last one ends it
         if (request_failed) begin
            dropped++;
            if (last_req) request_failed = 1'b0;
            return;
         end
         // destination is checked first, then source
         if (page_span(doff, left) > MAX_PAGES) begin
            push_error(cpbs_pkg::STATUS_DST_BIG, last_req);
            return;
         end
         if (page_span(soff, left) > MAX_PAGES) begin
            push_error(cpbs_pkg::STATUS_SRC_BIG, last_req);
            return;
         end
         while (left > 0) begin
            step = page_sz - doff;
            if (page_sz - soff < step) step = page_sz - soff;
            if (left < step) step = left;
            left -= step;
            c.status  = cpbs_pkg::STATUS_CHUNK;
            c.src_off = soff[cpbs_pkg::OFF_W-1:0];
            c.dst_off = doff[cpbs_pkg::OFF_W-1:0];
            c.src_idx = si;
            c.dst_idx = di;
            c.len     = step[cpbs_pkg::CHUNK_LEN_W-1:0];
            c.last    = (left == 0);
            expected_chunks.push_back(c);
            if (soff + step >= page_sz) si++;
            if (doff + step >= page_sz) di++;
            soff = (soff + step) & (page_sz - 1);
            doff = (doff + step) & (page_sz - 1);
         end
      endfunction

      function automatic int pending();
         return expected_chunks.size();
      endfunction

      function automatic void compare_field(string name, longint unsigned exp_val,
                                            longint unsigned act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      function automatic void check_chunk(logic [cpbs_pkg::STATUS_W-1:0] status,
                                          logic [cpbs_pkg::RSP_DATA_W-1:0] data, logic last);
         chunk_type e;
         if (expected_chunks.size() == 0) begin
            $error("response item with nothing outstanding: status %0d data %h",
                   status, data);
            mismatches++;
            return;
         end
         e = expected_chunks.pop_front();
         if (e.status == cpbs_pkg::STATUS_CHUNK) chunks_seen++;
         else errors_seen++;
         compare_field("status", e.status, status);
         compare_field("src_offset", e.src_off, data[SO_LSB +: cpbs_pkg::OFF_W]);
         compare_field("dst_offset", e.dst_off, data[DO_LSB +: cpbs_pkg::OFF_W]);
         compare_field("src_page_index", e.src_idx, data[SI_LSB +: cpbs_pkg::IDX_W]);
         compare_field("dst_page_index", e.dst_idx, data[DI_LSB +: cpbs_pkg::IDX_W]);
         compare_field("chunk_length", e.len, data[CL_LSB +: cpbs_pkg::CHUNK_LEN_W]);
         compare_field("last", e.last, last);
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [REQ_W-1:0]                  req_tdata;   // src_base, dst_base, seg_length
   logic                              req_tlast;   // last_in_request
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [cpbs_pkg::RSP_DATA_W-1:0]   rsp_tdata;   // src_offset, dst_offset, src_page_index,
                                                   // dst_page_index, chunk_length
   logic [cpbs_pkg::STATUS_W-1:0]     rsp_tuser;   // status
   logic                              rsp_tlast;   // last

   chunk_scoreboard sb = new();
   int burst_left;
   int idle_cycles = 0;

   copy_page_boundary_splitter_unit #(
      .PAGE_BITS  (PAGE_BITS),
      .MAX_PAGES  (MAX_PAGES),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: too long without any item moving on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response monitor, sampled on the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_chunk(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Receiver: changing ready patterns, plus one long hold-off once traffic
   // is flowing so the block backs up and stalls its input.
   initial begin
      int  mode;
      int  run_len;
      int  cyc;
      bit  long_hold_done;
      rsp_tready     = 1'b0;
      long_hold_done = 1'b0;
      cyc            = 0;
      wait (!reset);
      forever begin
         if (!long_hold_done && sb.chunks_seen > 80) begin
            long_hold_done = 1'b1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(20, 120);
         repeat (run_len) begin
            @(negedge clock);
            cyc++;
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= (cyc % 4) != 0;
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   // One segment: present at the falling edge, hold until taken.
   task automatic send_segment(input logic [47:0] src, input logic [47:0] dst,
                               input logic [31:0] seg_len, input logic last_req);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {seg_len, dst, src};
      req_tlast  <= last_req;
      do @(posedge clock); while (!req_tready);
      sb.plan_segment(src, dst, seg_len, last_req);
   endtask

   // Bursts of random length, random gaps between them.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
         gap        = $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic logic [47:0] rand_addr();
      logic [47:0] a;
      a = 48'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: begin
            a[PAGE_BITS-1:0] = PAGE_BITS'((1 << PAGE_BITS) - $urandom_range(1, 16));
         end
         1: begin
            a[PAGE_BITS-1:0] = PAGE_BITS'($urandom_range(0, 16));
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   function automatic logic [31:0] rand_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 32'd0;
      if (pick < 35) return $urandom_range(1, 256);
      if (pick < 65) return $urandom_range(1, 4096);
      if (pick < 85) return $urandom_range(1, 16384);
      // around the page-count limit: some fit, some fail
      if (pick < 94) return MAX_PAGES * (1 << PAGE_BITS) - 4096 + $urandom_range(0, 8192);
      return $urandom;
   endfunction

   localparam logic [47:0] ONES48   = '1;
   localparam int          PAGE_SZ  = 1 << PAGE_BITS;
   localparam int          FULL_LEN = MAX_PAGES * PAGE_SZ;

   initial begin
      int  nseg;
      bit  mid_pause_done;
      logic lst;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      burst_left     = 0;
      mid_pause_done = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed part, back to back.
      send_segment(48'h0, 48'h0, 32'd0, 1'b1);                  // zero length
      send_segment(48'h0, 48'h0, 32'd1, 1'b1);                  // single byte
      send_segment(48'h1000, 48'h5000, 32'd4096, 1'b1);         // one full page
      send_segment(48'h0fff, 48'h2000, 32'd2, 1'b1);            // source crosses at once
      send_segment(48'h3800, 48'h7100, 32'd10000, 1'b1);        // mixed boundaries
      send_segment(48'h0, 48'h0, FULL_LEN, 1'b1);               // exactly MAX_PAGES pages
      send_segment(48'h1, 48'h800, FULL_LEN - 2048, 1'b1);      // most chunks per segment
      send_segment(48'h0, 48'h1, FULL_LEN, 1'b0);               // destination too big
      send_segment(48'h0, 48'h0, 32'd100, 1'b0);                // dropped
      send_segment(48'h0, 48'h0, 32'd100, 1'b1);                // dropped, ends request
      send_segment(48'h123, 48'h456, 32'd300, 1'b1);            // back to normal
      send_segment(48'h1, 48'h0, FULL_LEN, 1'b1);               // source too big, on last
      send_segment(48'h10, 48'h20, 32'd50, 1'b1);               // not dropped
      send_segment(ONES48, ONES48, 32'hffff_ffff, 1'b0);        // both too big, longest
      send_segment(48'h0, 48'h0, 32'd0, 1'b1);                  // zero length, ends request
      send_segment(ONES48, ONES48, 32'd1, 1'b1);                // top addresses
      send_segment(ONES48, 48'h0, 32'd4097, 1'b1);
      send_segment(48'h0, ONES48, 32'd8191, 1'b0);
      send_segment(48'h0, 48'h0, 32'd0, 1'b0);                  // zero length, not last
      send_segment(48'hfff, 48'h0, FULL_LEN - 4095, 1'b1);      // source at limit
      drain_results();

      // Random requests of one to four segments; some with broken framing.
      while (sb.segments < N_ITEMS) begin
         nseg = $urandom_range(1, 4);
         for (int k = 0; k < nseg; k++) begin
            lst = (k == nseg - 1);
            if ($urandom_range(0, 9) == 0) lst = ~lst;
            send_segment(rand_addr(), rand_addr(), rand_len(), lst);
            pace_sender();
            if (!mid_pause_done && sb.segments > 110) begin
               mid_pause_done = 1'b1;
               drain_results();
            end
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d segments (%0d dropped in failed requests).",
               sb.segments, sb.dropped);
      $display("Checked %0d chunk items and %0d page-limit errors.",
               sb.chunks_seen, sb.errors_seen);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cpbs_pkg.sv
rtl/cpbs_step_unit.sv
rtl/copy_page_boundary_splitter_unit.sv
tb/copy_page_boundary_splitter_unit_tb.sv
